// ----- design/bpa_pkg.sv -----
// shared constants, codes and types of the bitmap page allocator
package bpa_pkg;

	// map geometry
	localparam int NUM_PAGES = 4096;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
	localparam int PAGE_W    = 12;
	localparam int CNT_W     = 13;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WORD_AW   = PAGE_W - BIT_W;
	localparam int CHG_W     = BIT_W + 1;
	localparam int FUNC_W    = 3;

	localparam logic [WORD_BITS-1:0] WORD_ONES  = '1;
	localparam logic [CNT_W-1:0]     PAGE_LIMIT = CNT_W'(NUM_PAGES);
	localparam logic [WORD_AW-1:0]   LAST_WORD  = WORD_AW'(NUM_WORDS - 1);

	// operation codes
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FUNC_ALLOC_ONE = 3'd0;
	localparam func_t FUNC_ALLOC_RUN = 3'd1;
	localparam func_t FUNC_FREE_ONE  = 3'd2;
	localparam func_t FUNC_FREE_RUN  = 3'd3;
	localparam func_t FUNC_RESERVE   = 3'd4;

	// word unit control and status
	typedef struct packed {
		logic             find_one;
		logic             set_bits;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} wu_ctl_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_W-1:0]     idx;
		logic [WORD_BITS-1:0] new_word;
		logic [CHG_W-1:0]     change_cnt;
	} wu_res_t;

	// map memory access
	typedef struct packed {
		logic                 clr;
		logic                 rd_en;
		logic [WORD_AW-1:0]   rd_addr;
		logic                 wr_en;
		logic [WORD_AW-1:0]   wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} ram_ctl_t;

endpackage

// ----- design/bpa_if.sv -----
// request, result and configuration channel interfaces
interface bpa_req_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	func_t               func;
	logic [PAGE_W-1:0]   base_page;
	logic [CNT_W-1:0]    page_count;

	modport source (output valid, output func, output base_page, output page_count,
		input ready);
	modport sink (input valid, input func, input base_page, input page_count,
		output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                ok;
	logic [PAGE_W-1:0]   granted_page;
	logic [CNT_W-1:0]    free_total;
	logic [CNT_W-1:0]    used_total;

	modport source (output valid, output ok, output granted_page, output free_total,
		output used_total, input ready);
	modport sink (input valid, input ok, input granted_page, input free_total,
		input used_total, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CNT_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/bpa_map_ram.sv -----
// used-bit map memory, one word per 32 pages, with per-word valid bits
module bpa_map_ram import bpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ram_ctl_t             ctl,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0] rd_data_q;

	// valid bits, a word never written reads as all used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= valid_q[ctl.rd_addr] ? mem[ctl.rd_addr] : WORD_ONES;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/bpa_word_unit.sv -----
// shared word unit: bit range mask, find first, set or clear, change count
module bpa_word_unit import bpa_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	input  wu_ctl_t              ctl,
	output wu_res_t              res
);

	logic [WORD_BITS-1:0] range;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] low_one;
	logic [WORD_BITS-1:0] change;
	logic [BIT_W-1:0]     idx;
	logic [CHG_W-1:0]     cnt;
	logic [2:0]           nib [WORD_BITS/4];

	// pages lo..hi of the word
	assign range = (WORD_ONES << ctl.lo) & (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - ctl.hi));

	// lowest matching bit in range
	assign cand    = (ctl.find_one ? word : ~word) & range;
	assign low_one = cand & (~cand + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low_one[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
	end

	// bits that actually change state
	assign change = ctl.set_bits ? (~word & range) : (word & range);

	// nibble counts, then their sum
	always_comb begin
		for (int n = 0; n < WORD_BITS / 4; n++) begin
			nib[n] = {2'b00, change[4*n]} + {2'b00, change[4*n+1]}
				+ {2'b00, change[4*n+2]} + {2'b00, change[4*n+3]};
		end
	end

	always_comb begin
		cnt = '0;
		for (int n = 0; n < WORD_BITS / 4; n++) begin
			cnt = cnt + CHG_W'(nib[n]);
		end
	end

	assign res.found      = |cand;
	assign res.idx        = idx;
	assign res.new_word   = ctl.set_bits ? (word | range) : (word & ~range);
	assign res.change_cnt = cnt;

endmodule

// ----- design/bitmap_page_allocator.sv -----
// bitmap page allocator top level: sequencer, counters and result register
//
// usage: one request on req (func, base_page, page_count) gives one result on
// rsp (ok, granted_page, free_total, used_total), in request order.
// req.ready is high only while the sequencer is idle; one request at a time.
// cfg writes page_total at any cfg.valid (cfg.ready stays high), marks every
// page used, sets the used count to the total (capped at 4096) and the hint to 0;
// write it only while no request is in flight.
// request sequence, set by the single map port and the shared word unit:
//   free one, free run, reserve run: setup, then rewrite of each word touched
//   alloc one: load, scan word by word from the hint with wrap, then as above
//   alloc run: load, scan words from page 0, rescanning at each free-run boundary,
//   then as above; longest on a badly fragmented map
// a finished result sits in the output register; the next request is taken
// while it waits, and the block holds its next result until rsp.ready.
// reset: all pages used, used count 4096, total 4096, hint 0; per-word valid
// bits make this immediate, no clearing pass.
module bitmap_page_allocator import bpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bpa_cfg_if.sink   cfg,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_RANGE = 6'b001000,
		S_RMW   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  page_total_q;
	logic [CNT_W-1:0]  used_count_q;
	logic [PAGE_W-1:0] hint_q;
	logic              out_valid_q;

	// per-request working registers
	func_t             func_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAGE_W-1:0] pos_q;
	logic              seek_used_q;
	logic              wrap_q;
	logic [WORD_AW-1:0] w0_q;
	logic [PAGE_W-1:0] span_first_q;
	logic              ok_q;
	logic [PAGE_W-1:0] granted_q;
	logic [PAGE_W-1:0] rs_q;
	logic [CNT_W-1:0]  rc_q;
	logic              set_q;
	logic [WORD_AW-1:0] cw_q;
	logic [PAGE_W-1:0] lp_q;

	// result register
	logic              out_ok_q;
	logic [PAGE_W-1:0] out_granted_q;
	logic [CNT_W-1:0]  out_free_q;
	logic [CNT_W-1:0]  out_used_q;

	logic [CNT_W-1:0]  tot;
	logic [CNT_W-1:0]  cfg_total;
	logic              req_acc;
	logic              cfg_acc;
	logic              fin_load;
	logic [PAGE_W-1:0] p0;

	ram_ctl_t             ram_ctl;
	logic [WORD_BITS-1:0] rd_data;
	wu_ctl_t              wu_ctl;
	wu_res_t              wu_res;

	logic [WORD_AW-1:0] scan_w;
	logic [WORD_AW:0]   scan_w_inc;
	logic [PAGE_W-1:0]  hit_page;
	logic [CNT_W-1:0]   next_word_end;
	logic [CNT_W-1:0]   run_len_hit;
	logic [CNT_W-1:0]   run_len_end;
	logic [CNT_W-1:0]   hint_inc;
	logic [PAGE_W-1:0]  hint_nxt;
	logic               scan_ok;
	logic               scan_fail;
	logic               scan_rd;
	logic [WORD_AW-1:0] scan_rd_w;
	logic [PAGE_W-1:0]  scan_page;

	logic [CNT_W:0]     re_full;
	logic [CNT_W-1:0]   re_cap;
	logic [CNT_W-1:0]   re_m1;
	logic               range_skip;
	logic [WORD_AW-1:0] lw;

	// effective total and handshakes
	assign tot       = (page_total_q > PAGE_LIMIT) ? PAGE_LIMIT : page_total_q;
	assign cfg_total = (cfg.data > PAGE_LIMIT) ? PAGE_LIMIT : cfg.data;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign p0        = ({1'b0, hint_q} < tot) ? hint_q : '0;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// scan position arithmetic
	assign scan_w        = pos_q[PAGE_W-1:BIT_W];
	assign scan_w_inc    = {1'b0, scan_w} + (WORD_AW + 1)'(1);
	assign hit_page      = {scan_w, wu_res.idx};
	assign next_word_end = {scan_w_inc, {BIT_W{1'b0}}};
	assign run_len_hit   = {1'b0, hit_page} - {1'b0, span_first_q};
	assign run_len_end   = next_word_end - {1'b0, span_first_q};
	assign hint_inc      = {1'b0, hit_page} + CNT_W'(1);
	assign hint_nxt      = (hint_inc < tot) ? hint_inc[PAGE_W-1:0] : '0;

	// scan decisions for the word in hand
	always_comb begin
		scan_ok   = 1'b0;
		scan_fail = 1'b0;
		scan_rd   = 1'b0;
		scan_rd_w = scan_w_inc[WORD_AW-1:0];
		scan_page = hit_page;
		if (func_q == FUNC_ALLOC_ONE) begin
			if (wu_res.found) begin
				scan_ok = 1'b1;
			end else if (wrap_q && (scan_w == w0_q)) begin
				scan_fail = 1'b1;
			end else begin
				scan_rd = 1'b1;
				if (!wrap_q && (scan_w == LAST_WORD)) begin
					scan_rd_w = '0;
				end
			end
		end else begin
			scan_page = span_first_q;
			if (!seek_used_q) begin
				if (!wu_res.found) begin
					if (scan_w == LAST_WORD) begin
						scan_fail = 1'b1;
					end else begin
						scan_rd = 1'b1;
					end
				end
			end else if (wu_res.found) begin
				if (run_len_hit >= count_q) begin
					scan_ok = 1'b1;
				end
			end else if (run_len_end >= count_q) begin
				scan_ok = 1'b1;
			end else if (scan_w == LAST_WORD) begin
				scan_fail = 1'b1;
			end else begin
				scan_rd = 1'b1;
			end
		end
	end

	// range bounds for the read-modify-write pass, sum kept one bit wider
	assign re_full    = {2'b00, rs_q} + {1'b0, rc_q};
	assign re_cap     = (re_full > {1'b0, tot}) ? tot : re_full[CNT_W-1:0];
	assign re_m1      = re_cap - CNT_W'(1);
	assign range_skip = ({1'b0, rs_q} >= tot);
	assign lw         = lp_q[PAGE_W-1:BIT_W];

	// word unit control
	always_comb begin
		wu_ctl.find_one = 1'b0;
		wu_ctl.set_bits = set_q;
		wu_ctl.lo       = '0;
		wu_ctl.hi       = '1;
		case (state_q)
			S_SCAN: begin
				wu_ctl.find_one = (func_q == FUNC_ALLOC_RUN) && seek_used_q;
				wu_ctl.set_bits = 1'b0;
				wu_ctl.lo       = pos_q[BIT_W-1:0];
			end
			S_RMW: begin
				wu_ctl.lo = (cw_q == rs_q[PAGE_W-1:BIT_W]) ? rs_q[BIT_W-1:0] : '0;
				wu_ctl.hi = (cw_q == lw) ? lp_q[BIT_W-1:0] : '1;
			end
			default: begin
				wu_ctl.find_one = 1'b0;
			end
		endcase
	end

	// map memory control
	always_comb begin
		ram_ctl.clr     = cfg_acc;
		ram_ctl.rd_en   = 1'b0;
		ram_ctl.rd_addr = scan_w;
		ram_ctl.wr_en   = 1'b0;
		ram_ctl.wr_addr = cw_q;
		ram_ctl.wr_data = wu_res.new_word;
		case (state_q)
			S_LOAD: begin
				ram_ctl.rd_en = 1'b1;
			end
			S_SCAN: begin
				ram_ctl.rd_en   = scan_rd;
				ram_ctl.rd_addr = scan_rd_w;
			end
			S_RANGE: begin
				ram_ctl.rd_en   = !range_skip;
				ram_ctl.rd_addr = rs_q[PAGE_W-1:BIT_W];
			end
			S_RMW: begin
				ram_ctl.rd_en   = (cw_q != lw);
				ram_ctl.rd_addr = cw_q + WORD_AW'(1);
				ram_ctl.wr_en   = 1'b1;
			end
			default: begin
				ram_ctl.rd_en = 1'b0;
			end
		endcase
	end

	bpa_map_ram u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ram_ctl),
		.rd_data (rd_data)
	);

	bpa_word_unit u_word (
		.word (rd_data),
		.ctl  (wu_ctl),
		.res  (wu_res)
	);

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			page_total_q <= PAGE_LIMIT;
			used_count_q <= PAGE_LIMIT;
			hint_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req.func)
							FUNC_ALLOC_ONE: begin
								state_q <= S_LOAD;
							end
							FUNC_ALLOC_RUN: begin
								state_q <= (req.page_count == '0) ? S_FIN : S_LOAD;
							end
							FUNC_FREE_ONE: begin
								state_q <= S_RANGE;
							end
							FUNC_FREE_RUN, FUNC_RESERVE: begin
								state_q <= (req.page_count == '0) ? S_FIN : S_RANGE;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_LOAD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_ok) begin
						state_q <= S_RANGE;
						if (func_q == FUNC_ALLOC_ONE) begin
							hint_q <= hint_nxt;
						end
					end else if (scan_fail) begin
						state_q <= S_FIN;
					end
				end
				S_RANGE: begin
					state_q <= range_skip ? S_FIN : S_RMW;
				end
				S_RMW: begin
					used_count_q <= set_q ? (used_count_q + CNT_W'(wu_res.change_cnt))
						: (used_count_q - CNT_W'(wu_res.change_cnt));
					if (cw_q == lw) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// result register occupancy
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// configuration write reinitializes the map
			if (cfg_acc) begin
				page_total_q <= cfg.data;
				used_count_q <= cfg_total;
				hint_q       <= '0;
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					func_q      <= req.func;
					count_q     <= req.page_count;
					granted_q   <= '0;
					seek_used_q <= 1'b0;
					wrap_q      <= 1'b0;
					pos_q       <= (req.func == FUNC_ALLOC_ONE) ? p0 : '0;
					w0_q        <= p0[PAGE_W-1:BIT_W];
					rs_q        <= req.base_page;
					rc_q        <= (req.func == FUNC_FREE_ONE) ? CNT_W'(1) : req.page_count;
					set_q       <= (req.func == FUNC_RESERVE);
					ok_q        <= (req.func == FUNC_FREE_ONE) || (((req.func == FUNC_FREE_RUN)
						|| (req.func == FUNC_RESERVE)) && (req.page_count != '0));
				end
			end
			S_SCAN: begin
				if (scan_ok) begin
					rs_q      <= scan_page;
					rc_q      <= (func_q == FUNC_ALLOC_ONE) ? CNT_W'(1) : count_q;
					set_q     <= 1'b1;
					ok_q      <= 1'b1;
					granted_q <= scan_page;
				end else if (scan_rd) begin
					pos_q <= {scan_rd_w, {BIT_W{1'b0}}};
					if ((func_q == FUNC_ALLOC_ONE) && !wrap_q && (scan_w == LAST_WORD)) begin
						wrap_q <= 1'b1;
					end
				end else if (!scan_fail) begin
					// run boundary inside the same word
					pos_q       <= hit_page;
					seek_used_q <= !seek_used_q;
					if (!seek_used_q) begin
						span_first_q <= hit_page;
					end
				end
			end
			S_RANGE: begin
				cw_q <= rs_q[PAGE_W-1:BIT_W];
				lp_q <= re_m1[PAGE_W-1:0];
			end
			S_RMW: begin
				cw_q <= cw_q + WORD_AW'(1);
			end
			default: begin
				cw_q <= cw_q;
			end
		endcase

		if (fin_load) begin
			out_ok_q      <= ok_q;
			out_granted_q <= granted_q;
			out_free_q    <= tot - used_count_q;
			out_used_q    <= used_count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.ok           = out_ok_q;
	assign rsp.granted_page = out_granted_q;
	assign rsp.free_total   = out_free_q;
	assign rsp.used_total   = out_used_q;

`ifndef NO_ASSERTIONS
	// used count never exceeds the effective total
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= tot)
		else $error("used count above page total");

	// free and used totals of a result add up to the total
	a_totals_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (({1'b0, rsp.free_total} + {1'b0, rsp.used_total}) == {1'b0, tot}))
		else $error("free plus used differs from total");

	// a failed result grants page zero
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ok) |-> (rsp.granted_page == '0))
		else $error("granted page set on a failed result");

	// an accepted request makes the block busy
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("ready right after an accepted request");
`endif

endmodule

// ----- tb/sv/bitmap_page_allocator_tb.sv -----
// self-checking testbench of the bitmap page allocator with its own page map model
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	// codes the block treats as no operation
	localparam func_t FUNC_BAD_LO  = 3'd5;
	localparam func_t FUNC_BAD_MID = 3'd6;
	localparam func_t FUNC_BAD_HI  = 3'd7;

	localparam int CYCLE_LIMIT = 50_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic              ok;
		logic [PAGE_W-1:0] granted;
		logic [CNT_W-1:0]  free_cnt;
		logic [CNT_W-1:0]  used_cnt;
	} page_status_t;

	typedef struct packed {
		func_t             func;
		logic [PAGE_W-1:0] start;
		logic [CNT_W-1:0]  count;
		logic              typed;
		page_status_t      want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bpa_cfg_if cfg_ch ();
	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	bitmap_page_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator model state
	bit              page_busy [NUM_PAGES];
	int              busy_count;
	int              next_hint;
	logic [CNT_W-1:0] cfg_total;

	// expected results in request order
	page_status_t status_q [$];
	page_status_t got_status;
	page_status_t want_status;

	// typed expectation travelling with the current request
	logic         row_typed;
	page_status_t row_want;

	int req_idle_pct;
	int rsp_idle_pct;
	int fails;
	int checked;
	int cycles;
	int cfg_writes;
	int dir_sent;
	int rand_sent;

	int phase_total [NUM_PHASES] = '{64, 1, 0, 300, 4096, 8191, 2047, 100};
	int phase_items [NUM_PHASES] = '{400, 100, 60, 400, 250, 100, 200, 440};

	// directed rows, starting from the reset state with 4096 pages all used
	dir_row_t dir_tab [0:24] = '{
		'{FUNC_ALLOC_ONE, 12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,    13'd0,    13'd4096}},
		'{FUNC_ALLOC_RUN, 12'd0,    13'd1,    1'b1, '{1'b0, 12'd0,    13'd0,    13'd4096}},
		'{FUNC_FREE_ONE,  12'd0,    13'd0,    1'b1, '{1'b1, 12'd0,    13'd1,    13'd4095}},
		'{FUNC_ALLOC_ONE, 12'd0,    13'd0,    1'b1, '{1'b1, 12'd0,    13'd0,    13'd4096}},
		'{FUNC_FREE_RUN,  12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,    13'd0,    13'd4096}},
		'{FUNC_FREE_RUN,  12'd4000, 13'd8191, 1'b1, '{1'b1, 12'd0,    13'd96,   13'd4000}},
		'{FUNC_FREE_ONE,  12'd4095, 13'd0,    1'b1, '{1'b1, 12'd0,    13'd96,   13'd4000}},
		'{FUNC_ALLOC_ONE, 12'd0,    13'd0,    1'b1, '{1'b1, 12'd4000, 13'd95,   13'd4001}},
		'{FUNC_ALLOC_RUN, 12'd0,    13'd95,   1'b1, '{1'b1, 12'd4001, 13'd0,    13'd4096}},
		'{FUNC_FREE_RUN,  12'd0,    13'd4096, 1'b1, '{1'b1, 12'd0,    13'd4096, 13'd0}},
		'{FUNC_ALLOC_RUN, 12'd0,    13'd4096, 1'b1, '{1'b1, 12'd0,    13'd0,    13'd4096}},
		'{FUNC_FREE_RUN,  12'd0,    13'd4096, 1'b1, '{1'b1, 12'd0,    13'd4096, 13'd0}},
		'{FUNC_ALLOC_RUN, 12'd4095, 13'd4097, 1'b1, '{1'b0, 12'd0,    13'd4096, 13'd0}},
		'{FUNC_ALLOC_RUN, 12'd0,    13'd8191, 1'b1, '{1'b0, 12'd0,    13'd4096, 13'd0}},
		'{FUNC_RESERVE,   12'd4095, 13'd1,    1'b1, '{1'b1, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_RESERVE,   12'd4095, 13'd8191, 1'b1, '{1'b1, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_RESERVE,   12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_BAD_LO,    12'd4095, 13'd8191, 1'b1, '{1'b0, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_BAD_MID,   12'd0,    13'd4,    1'b1, '{1'b0, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_BAD_HI,    12'd4095, 13'd8191, 1'b1, '{1'b0, 12'd0,    13'd4095, 13'd1}},
		'{FUNC_ALLOC_ONE, 12'd0,    13'd0,    1'b0, '0},
		'{FUNC_ALLOC_ONE, 12'd4095, 13'd8191, 1'b0, '0},
		'{FUNC_FREE_ONE,  12'd4001, 13'd0,    1'b0, '0},
		'{FUNC_RESERVE,   12'd0,    13'd2048, 1'b0, '0},
		'{FUNC_ALLOC_RUN, 12'd0,    13'd3,    1'b0, '0}
	};

	function automatic int effective_total();
		return (cfg_total > CNT_W'(NUM_PAGES)) ? NUM_PAGES : int'(cfg_total);
	endfunction

	// every page used, count equal to the total, hint back to page 0
	function automatic void reinit_map();
		foreach (page_busy[i])
			page_busy[i] = 1'b1;
		busy_count = effective_total();
		next_hint = 0;
	endfunction

	// apply one request to the model map and return its status
	function automatic page_status_t allocate_step(func_t f, logic [PAGE_W-1:0] s,
			logic [CNT_W-1:0] c);
		int           total;
		int           p;
		int           i;
		int           span_first;
		int           run_len;
		bit           done;
		page_status_t st;
		total = effective_total();
		st = '0;
		done = 1'b0;
		span_first = 0;
		run_len = 0;
		case (f)
			FUNC_ALLOC_ONE: begin
				// next fit from the hint with wrap
				p = (next_hint < total) ? next_hint : 0;
				for (i = 0; i < total && !done; i++) begin
					if (!page_busy[p]) begin
						page_busy[p] = 1'b1;
						busy_count++;
						next_hint = (p + 1 < total) ? p + 1 : 0;
						st.ok = 1'b1;
						st.granted = PAGE_W'(p);
						done = 1'b1;
					end else begin
						p = (p + 1 < total) ? p + 1 : 0;
					end
				end
			end
			FUNC_ALLOC_RUN: begin
				// first fit from page 0, hint untouched
				if (c != 0) begin
					for (i = 0; i < total && !done; i++) begin
						if (page_busy[i]) begin
							run_len = 0;
						end else begin
							if (run_len == 0)
								span_first = i;
							run_len++;
							if (run_len == int'(c)) begin
								for (p = span_first; p < span_first + int'(c); p++)
									page_busy[p] = 1'b1;
								busy_count += int'(c);
								st.ok = 1'b1;
								st.granted = PAGE_W'(span_first);
								done = 1'b1;
							end
						end
					end
				end
			end
			FUNC_FREE_ONE: begin
				st.ok = 1'b1;
				if (int'(s) < total && page_busy[s]) begin
					page_busy[s] = 1'b0;
					busy_count--;
				end
			end
			FUNC_FREE_RUN, FUNC_RESERVE: begin
				// pages past the total end the run
				if (c != 0) begin
					st.ok = 1'b1;
					for (i = 0; i < int'(c) && !done; i++) begin
						p = int'(s) + i;
						if (p >= total) begin
							done = 1'b1;
						end else if (f == FUNC_FREE_RUN && page_busy[p]) begin
							page_busy[p] = 1'b0;
							busy_count--;
						end else if (f == FUNC_RESERVE && !page_busy[p]) begin
							page_busy[p] = 1'b1;
							busy_count++;
						end
					end
				end
			end
			default: begin
			end
		endcase
		st.free_cnt = CNT_W'(total - busy_count);
		st.used_cnt = CNT_W'(busy_count);
		return st;
	endfunction

	task automatic flag_failure(input string msg);
		fails++;
		if (fails <= 10)
			$display("%s", msg);
	endtask

	// monitor: results against the queue, config and request acceptance into the model
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_status = '{rsp_ch.ok, rsp_ch.granted_page, rsp_ch.free_total,
					rsp_ch.used_total};
				if (status_q.size() == 0) begin
					flag_failure($sformatf("unexpected result ok=%0d page=%0d free=%0d used=%0d",
						got_status.ok, got_status.granted, got_status.free_cnt,
						got_status.used_cnt));
				end else begin
					want_status = status_q.pop_front();
					checked++;
					if (got_status.ok !== want_status.ok ||
							got_status.granted !== want_status.granted ||
							got_status.free_cnt !== want_status.free_cnt ||
							got_status.used_cnt !== want_status.used_cnt)
						flag_failure({
							$sformatf("result %0d: expected ok=%0d page=%0d free=%0d used=%0d",
								checked, want_status.ok, want_status.granted,
								want_status.free_cnt, want_status.used_cnt),
							$sformatf(", got ok=%0d page=%0d free=%0d used=%0d",
								got_status.ok, got_status.granted,
								got_status.free_cnt, got_status.used_cnt)});
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				cfg_total = cfg_ch.data;
				reinit_map();
			end
			if (req_ch.valid && req_ch.ready) begin
				want_status = allocate_step(req_ch.func, req_ch.base_page, req_ch.page_count);
				status_q.push_back(row_typed ? row_want : want_status);
			end
		end
	end

	// result side stalls
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);

	// one request, with random idle cycles ahead of it
	task automatic send_request(input func_t f, input logic [PAGE_W-1:0] s,
			input logic [CNT_W-1:0] c, input logic typed, input page_status_t want);
		while ($urandom_range(99) < req_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.func       <= f;
		req_ch.base_page  <= s;
		req_ch.page_count <= c;
		row_typed         <= typed;
		row_want          <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// hold off new requests until every result is back
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_total(input logic [CNT_W-1:0] value);
		drain_results();
		repeat (8) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
	endtask

	// run limit
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bitmap_page_allocator regression: fail");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int               total;
		int               r;
		int               k;
		func_t            f;
		logic [PAGE_W-1:0] s;
		logic [CNT_W-1:0]  c;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ALLOC_ONE;
		req_ch.base_page = '0;
		req_ch.page_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		req_idle_pct = 29;
		rsp_idle_pct = 71;
		fails = 0;
		checked = 0;
		cfg_writes = 0;
		dir_sent = 0;
		rand_sent = 0;
		cfg_total = CNT_W'(NUM_PAGES);
		reinit_map();

		// reset
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows from the reset state
		foreach (dir_tab[i]) begin
			send_request(dir_tab[i].func, dir_tab[i].start, dir_tab[i].count,
				dir_tab[i].typed, dir_tab[i].want);
			dir_sent++;
		end

		// random phases, one page total each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_total(CNT_W'(phase_total[ph]));
			total = (phase_total[ph] > NUM_PAGES) ? NUM_PAGES : phase_total[ph];
			// open up the map so allocations get going
			send_request(FUNC_FREE_RUN, '0, CNT_W'(total), 1'b0, '0);
			for (int n = 0; n < phase_items[ph]; n++) begin
				// idle ratios: sender light, then receiver light, then none
				if (rand_sent < 650) begin
					req_idle_pct = 29;
					rsp_idle_pct = 71;
				end else if (rand_sent < 1300) begin
					req_idle_pct = 71;
					rsp_idle_pct = 29;
				end else begin
					req_idle_pct = 0;
					rsp_idle_pct = 0;
				end
				r = $urandom_range(99);
				if (r < 30)
					f = FUNC_ALLOC_ONE;
				else if (r < 45)
					f = FUNC_ALLOC_RUN;
				else if (r < 65)
					f = FUNC_FREE_ONE;
				else if (r < 80)
					f = FUNC_FREE_RUN;
				else if (r < 93)
					f = FUNC_RESERVE;
				else
					f = func_t'(FUNC_BAD_LO + $urandom_range(FUNC_BAD_HI - FUNC_BAD_LO));
				if ($urandom_range(9) == 0 || total == 0)
					s = PAGE_W'($urandom_range(NUM_PAGES - 1));
				else
					s = PAGE_W'($urandom_range(total - 1));
				k = $urandom_range(19);
				if (k == 0)
					c = '0;
				else if (k == 1)
					c = CNT_W'($urandom_range(8191));
				else if (k <= 4)
					c = CNT_W'($urandom_range(total + 1));
				else
					c = CNT_W'($urandom_range(8, 1));
				send_request(f, s, c, 1'b0, '0);
				rand_sent++;
				// occasional full pause of the sender
				if ($urandom_range(99) == 0)
					drain_results();
			end
		end

		// wind down
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (status_q.size() != 0)
			flag_failure($sformatf("%0d results never arrived", status_q.size()));

		$display("covered %0d directed and %0d random requests, %0d results checked",
			dir_sent, rand_sent, checked);
		$display("over %0d page total writes incl. zero and oversize, with mixed stalls",
			cfg_writes);
		if (fails == 0)
			$display("bitmap_page_allocator regression: pass");
		else
			$display("bitmap_page_allocator regression: fail");
		$finish;
	end

endmodule
